@@ rtl/core/dtas_pkg.sv @@
package dtas_pkg;

  // Field widths of the channel words.
  localparam int ACTION_W  = 2;
  localparam int DEPTH_W   = 16;
  localparam int COLUMN_W  = 10;
  localparam int BIN_SEL_W = 9;
  localparam int DIST_W    = 17;

  // Range scale factor, unsigned Q1.17.
  localparam int SCALE_W    = 18;
  localparam int SCALE_FRAC = 17;

  // Angle fixed point used while the column table is built.
  localparam int ANG_FRAC = 48;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // Restoring division. Only evaluated while the table is elaborated.
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Alternating arctangent series of p/q with every term truncated.
  function automatic logic [63:0] atan_series(input logic [63:0] p, input logic [63:0] q);
    logic [63:0] pw;
    logic [63:0] sum;
    logic [63:0] term;
    pw  = udiv(p << ANG_FRAC, q);
    sum = '0;
    for (int n = 0; n < 80; n++) begin
      if (pw != 64'd0) begin
        term = udiv(pw, 64'(2 * n + 1));
        if ((n % 2) == 0) begin
          sum = sum + term;
        end else begin
          sum = sum - term;
        end
        pw = udiv(pw * p, q);
        pw = udiv(pw * p, q);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] pi_q_calc();
    return 64'd16 * atan_series(64'd1, 64'd5) - 64'd4 * atan_series(64'd1, 64'd239);
  endfunction

  localparam logic [63:0] PI_Q = pi_q_calc();

  // Arctangent of a/b for a <= b, reduced around pi/4 for larger ratios.
  function automatic logic [63:0] atan_unit(input logic [63:0] a, input logic [63:0] b);
    if (64'd5 * a <= 64'd2 * b) begin
      return atan_series(a, b);
    end
    return (PI_Q >> 2) - atan_series(b - a, a + b);
  endfunction

  function automatic logic [63:0] atan_ratio(input logic [63:0] a, input logic [63:0] b);
    if (a <= b) begin
      return atan_unit(a, b);
    end
    return (PI_Q >> 1) - atan_unit(b, a);
  endfunction

  // Integer square root, two bits per step.
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bits;
    x    = x_in;
    res  = '0;
    bits = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bits > x) begin
        bits = bits >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bits != 64'd0) begin
        if (x >= res + bits) begin
          x   = x - (res + bits);
          res = (res >> 1) + bits;
        end else begin
          res = res >> 1;
        end
        bits = bits >> 2;
      end
    end
    return res;
  endfunction

  // Angular bin of one image column, clamped to the bin range.
  function automatic int col_bin(input int c, input int columns, input int bin_count,
                                 input int focal);
    longint      num;
    longint      bin;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] k;
    num = 2 * longint'(c) - longint'(columns - 1);
    a   = (num < 0) ? 64'(-num) : 64'(num);
    b   = 64'(2 * focal);
    k   = udiv(64'd360 * atan_ratio(a, b), PI_Q);
    if (num > 0) begin
      bin = longint'(bin_count >> 1) - longint'(k);
    end else begin
      bin = longint'(bin_count >> 1) + longint'(k);
    end
    if (bin < 0) begin
      bin = 0;
    end
    if (bin > longint'(bin_count - 1)) begin
      bin = longint'(bin_count - 1);
    end
    return int'(bin);
  endfunction

  // Range scale sqrt(1 + t^2) of one column, Q1.17 rounded, saturated.
  function automatic logic [SCALE_W-1:0] col_scale(input int c, input int columns,
                                                   input int focal);
    longint      num;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] v;
    logic [63:0] s;
    num = 2 * longint'(c) - longint'(columns - 1);
    a   = (num < 0) ? 64'(-num) : 64'(num);
    b   = 64'(2 * focal);
    v   = udiv(isqrt64((a * a + b * b) << 36), b);
    s   = (v + 64'd1) >> 1;
    if (s > 64'((1 << SCALE_W) - 1)) begin
      s = 64'((1 << SCALE_W) - 1);
    end
    return s[SCALE_W-1:0];
  endfunction

endpackage

@@ rtl/core/dtas_if.sv @@
// Pixel, read and clear requests.
interface dtas_in_if;
  logic                           valid;
  logic                           ready;
  logic [dtas_pkg::ACTION_W-1:0]  action;
  logic [dtas_pkg::DEPTH_W-1:0]   depth_mm;
  logic [dtas_pkg::COLUMN_W-1:0]  column;
  logic [dtas_pkg::BIN_SEL_W-1:0] bin_select;

  modport source (output valid, action, depth_mm, column, bin_select, input ready);
  modport sink   (input valid, action, depth_mm, column, bin_select, output ready);
endinterface

// Bin read results.
interface dtas_out_if;
  logic                           valid;
  logic                           ready;
  logic [dtas_pkg::BIN_SEL_W-1:0] bin_index;
  logic [dtas_pkg::DIST_W-1:0]    distance;

  modport source (output valid, bin_index, distance, input ready);
  modport sink   (input valid, bin_index, distance, output ready);
endinterface

@@ rtl/core/dtas_col_table.sv @@
module dtas_col_table #(
  parameter int COLUMNS      = 640,
  parameter int BINS         = 360,
  parameter int FOCAL_PIXELS = 595
) (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [$clog2(COLUMNS)-1:0]         rd_addr,
  output logic [$clog2(BINS)-1:0]            rd_bin,
  output logic [dtas_pkg::SCALE_W-1:0]       rd_scale
);

  localparam int BIN_W   = $clog2(BINS);
  localparam int ENTRY_W = BIN_W + dtas_pkg::SCALE_W;

  typedef logic [ENTRY_W-1:0] rom_t [COLUMNS];

  // Every column's bin and range scale, computed during elaboration.
  function automatic rom_t build_rom();
    rom_t rom;
    for (int c = 0; c < COLUMNS; c++) begin
      rom[c] = {BIN_W'(dtas_pkg::col_bin(c, COLUMNS, BINS, FOCAL_PIXELS)),
                dtas_pkg::col_scale(c, COLUMNS, FOCAL_PIXELS)};
    end
    return rom;
  endfunction

  localparam rom_t COL_ROM = build_rom();

  logic [ENTRY_W-1:0] entry_r;

  // Registered read; the entry holds until the next accepted word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      entry_r <= COL_ROM[rd_addr];
    end
  end

  assign rd_bin   = entry_r[ENTRY_W-1:dtas_pkg::SCALE_W];
  assign rd_scale = entry_r[dtas_pkg::SCALE_W-1:0];

endmodule

@@ rtl/core/depth_to_angular_scan_top.sv @@
// Angular range scan built from a depth pixel stream.
// in_ch carries one word per request: a pixel (depth in mm and image column),
// a read of one angular bin, or a clear of all bins. out_ch returns one word
// for each read: the requested bin index and its nearest distance, 0 if empty.
// Pixels with zero depth or a column past the image width are dropped.
// Throughput is one word per cycle for pixels and reads while no clear or
// held read stalls in_ch. The pipeline is column table lookup, then depth
// multiply and bin store read, then the min update or the read result; a
// read result passes through stage 1, stage 2 and the output register.
// Back-to-back pixels on one bin are forwarded. A clear waits for the words
// ahead of it, then sweeps the bin store one entry per cycle with
// in_ch.ready low. After reset the same sweep runs before the first word
// is taken.
// When out_ch stalls, pixels keep flowing; a read waiting behind a full
// output register holds the pipeline and drops in_ch.ready.
module depth_to_angular_scan_top #(
  parameter int COLUMNS      = 640,
  parameter int BINS         = 360,
  parameter int FOCAL_PIXELS = 595
) (
  input  logic        clk,
  input  logic        rst_n,
  dtas_in_if.sink     in_ch,
  dtas_out_if.source  out_ch
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int BIN_W  = $clog2(BINS);
  localparam int PROD_W = dtas_pkg::DEPTH_W + dtas_pkg::SCALE_W;

  typedef enum logic {ST_RUN, ST_SWEEP} state_t;

  state_t                          state_r;
  logic [BIN_W-1:0]                sweep_cnt_r;
  logic                            sweeping;

  logic                            pipe_adv;
  logic                            in_acc;
  logic                            in_col_ok;
  logic [COL_W-1:0]                tbl_addr;
  logic [BIN_W-1:0]                tbl_bin;
  logic [dtas_pkg::SCALE_W-1:0]    tbl_scale;

  // Stage 1: accepted word plus table entry.
  logic                            s1_vld_r;
  logic [dtas_pkg::ACTION_W-1:0]   s1_act_r;
  logic [dtas_pkg::DEPTH_W-1:0]    s1_depth_r;
  logic [dtas_pkg::BIN_SEL_W-1:0]  s1_sel_r;
  logic                            s1_pix_ok_r;
  logic                            s1_sel_ok_r;
  logic [BIN_W-1:0]                s1_addr;
  logic [PROD_W-1:0]               s1_prod;
  logic [dtas_pkg::DIST_W-1:0]     s2_dist_nxt;

  // Stage 2: distance and store data.
  logic                            s2_vld_r;
  logic [dtas_pkg::ACTION_W-1:0]   s2_act_r;
  logic [dtas_pkg::BIN_SEL_W-1:0]  s2_sel_r;
  logic                            s2_pix_ok_r;
  logic                            s2_sel_ok_r;
  logic [BIN_W-1:0]                s2_bin_r;
  logic [dtas_pkg::DIST_W-1:0]     s2_dist_r;
  logic [dtas_pkg::DIST_W-1:0]     s2_old;
  logic                            s2_is_read;
  logic                            s2_is_clear;
  logic                            pix_we;

  // Last store write, for a read issued on the same edge.
  logic                            byp_vld_r;
  logic [BIN_W-1:0]                byp_bin_r;
  logic [dtas_pkg::DIST_W-1:0]     byp_data_r;

  // Bin store.
  logic [dtas_pkg::DIST_W-1:0]     bin_mem [BINS];
  logic [dtas_pkg::DIST_W-1:0]     mem_q_r;
  logic                            mem_we;
  logic [BIN_W-1:0]                mem_waddr;
  logic [dtas_pkg::DIST_W-1:0]     mem_wdata;
  logic                            mem_re;

  // Output register.
  logic                            out_valid_r;
  logic [dtas_pkg::BIN_SEL_W-1:0]  out_bin_r;
  logic [dtas_pkg::DIST_W-1:0]     out_dist_r;
  logic                            out_load;

  assign sweeping    = (state_r == ST_SWEEP);
  assign s2_is_read  = s2_vld_r && (s2_act_r == dtas_pkg::ACT_READ);
  assign s2_is_clear = s2_vld_r && (s2_act_r == dtas_pkg::ACT_CLEAR);

  // Only a read that cannot leave stage 2 holds the pipeline.
  assign pipe_adv = !(s2_is_read && out_valid_r && !out_ch.ready);

  // No new word while a clear is in flight or the store is being swept.
  assign in_ch.ready = pipe_adv && !sweeping
                       && !(s1_vld_r && (s1_act_r == dtas_pkg::ACT_CLEAR))
                       && !s2_is_clear;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign in_col_ok = (32'(in_ch.column) < COLUMNS);
  assign tbl_addr  = in_col_ok ? COL_W'(32'(in_ch.column)) : '0;

  dtas_col_table #(
    .COLUMNS      (COLUMNS),
    .BINS         (BINS),
    .FOCAL_PIXELS (FOCAL_PIXELS)
  ) u_col_table (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_addr  (tbl_addr),
    .rd_bin   (tbl_bin),
    .rd_scale (tbl_scale)
  );

  // Stage 1 valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (pipe_adv) begin
      s1_vld_r <= in_acc;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_act_r    <= in_ch.action;
      s1_depth_r  <= in_ch.depth_mm;
      s1_sel_r    <= in_ch.bin_select;
      s1_pix_ok_r <= in_col_ok && (in_ch.depth_mm != '0);
      s1_sel_ok_r <= (32'(in_ch.bin_select) < BINS);
    end
  end

  // Store address: the requested bin for a read, the column's bin otherwise.
  always_comb begin
    if (s1_act_r == dtas_pkg::ACT_READ) begin
      s1_addr = s1_sel_ok_r ? BIN_W'(32'(s1_sel_r)) : '0;
    end else begin
      s1_addr = tbl_bin;
    end
  end

  // Planar distance, floor(depth * scale).
  assign s1_prod     = PROD_W'(s1_depth_r) * PROD_W'(tbl_scale);
  assign s2_dist_nxt = s1_prod[dtas_pkg::SCALE_FRAC +: dtas_pkg::DIST_W];

  // Stage 2 valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (pipe_adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  // Stage 2 payload.
  always_ff @(posedge clk) begin
    if (pipe_adv && s1_vld_r) begin
      s2_act_r    <= s1_act_r;
      s2_sel_r    <= s1_sel_r;
      s2_pix_ok_r <= s1_pix_ok_r;
      s2_sel_ok_r <= s1_sel_ok_r;
      s2_bin_r    <= s1_addr;
      s2_dist_r   <= s2_dist_nxt;
    end
  end

  // Current bin contents, with the write of the previous edge forwarded.
  assign s2_old = (byp_vld_r && (byp_bin_r == s2_bin_r)) ? byp_data_r : mem_q_r;

  // Keep the nearest nonzero distance.
  assign pix_we = pipe_adv && s2_vld_r && (s2_act_r == dtas_pkg::ACT_PIXEL)
                  && s2_pix_ok_r && ((s2_old == '0) || (s2_old > s2_dist_r));

  // Forwarding register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_vld_r <= 1'b0;
    end else if (sweeping) begin
      byp_vld_r <= 1'b0;
    end else if (pipe_adv) begin
      byp_vld_r <= pix_we;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      byp_bin_r  <= s2_bin_r;
      byp_data_r <= s2_dist_r;
    end
  end

  // One write port shared by the sweep and the min update.
  assign mem_we    = sweeping || pix_we;
  assign mem_waddr = sweeping ? sweep_cnt_r : s2_bin_r;
  assign mem_wdata = sweeping ? '0 : s2_dist_r;
  assign mem_re    = pipe_adv && s1_vld_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= bin_mem[s1_addr];
    end
  end

  // Sweep control: runs after reset and for every clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_cnt_r <= '0;
    end else begin
      unique case (state_r)
        ST_RUN: begin
          if (pipe_adv && s2_is_clear) begin
            state_r     <= ST_SWEEP;
            sweep_cnt_r <= '0;
          end
        end
        ST_SWEEP: begin
          if (sweep_cnt_r == BIN_W'(BINS - 1)) begin
            state_r <= ST_RUN;
          end
          sweep_cnt_r <= sweep_cnt_r + 1'b1;
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  // Output register for read results.
  assign out_load = pipe_adv && s2_is_read;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_r  <= s2_sel_r;
      out_dist_r <= s2_sel_ok_r ? s2_old : '0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.bin_index = out_bin_r;
  assign out_ch.distance  = out_dist_r;

  // A clear reaching stage 2 has nothing behind it.
  a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
    s2_is_clear |-> !s1_vld_r)
    else $error("word behind a clear entered the pipeline");

  // The pipeline stays empty while the sweep runs.
  a_sweep_empty: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping |-> (!s1_vld_r && !s2_vld_r && !pix_we))
    else $error("pipeline active during bin store sweep");

  // A nonzero depth always yields a nonzero stored distance.
  a_dist_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pix_we |-> (s2_dist_r != '0))
    else $error("zero distance written to bin store");

  // A read leaving stage 2 shows up on the output next cycle.
  a_read_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (out_bin_r == $past(s2_sel_r))))
    else $error("read result lost");

endmodule
